FILE: hw/rtl/bbp_pkg.sv
// bbp_pkg: shared types and codes for the buzzer beep pattern generator
// no dependencies; imported by bbp_mul, bbp_div and the top level
package bbp_pkg;

  // command codes carried in the mode field
  localparam logic [2:0] MODE_TICK   = 3'd0;
  localparam logic [2:0] MODE_SINGLE = 3'd1;
  localparam logic [2:0] MODE_REPEAT = 3'd2;
  localparam logic [2:0] MODE_STOP   = 3'd3;
  localparam logic [2:0] MODE_TONE   = 3'd4;

  // pattern codes
  localparam logic [1:0] PAT_NONE   = 2'd0;
  localparam logic [1:0] PAT_SINGLE = 2'd1;
  localparam logic [1:0] PAT_REPEAT = 2'd2;

  // configuration register indexes
  localparam logic CFG_TIMER_CLOCK = 1'b0;
  localparam logic CFG_PRESCALE    = 1'b1;

  localparam logic [31:0] TIMER_CLOCK_RST = 32'd84000000;
  localparam logic [15:0] PRESCALE_RST    = 16'd83;
  localparam logic [15:0] FREQ_RST        = 16'd1000;
  localparam logic [15:0] ELAPSED_MAX     = 16'hFFFF;

  localparam int MUL_STEPS = 16;
  localparam int DIV_STEPS = 32;

  typedef struct packed {
    logic [2:0]         mode;
    logic [15:0]        tone_freq;
    logic [15:0]        on_time;
    logic [15:0]        off_time;
    logic signed [15:0] beep_count;
  } bbp_in_t;

  typedef struct packed {
    logic        pin_driven;
    logic [31:0] reload_value;
    logic [31:0] compare_value;
    logic        counter_clear;
    logic [1:0]  pattern_mode;
    logic        sounding;
  } bbp_out_t;

endpackage

FILE: hw/rtl/buzzer_beep_pattern_generator.sv
// buzzer_beep_pattern_generator: beep pattern sequencer with PWM reload computation
// depends on bbp_pkg, bbp_mul, bbp_div
//
//   channel | signals                            | handshake
//   --------+------------------------------------+-----------------------
//   input   | in_valid, in_ready, in_data        | valid/ready
//   result  | out_valid, out_ready, out_data     | valid/ready
//   config  | cfg_we, cfg_addr, cfg_wdata        | write on cfg_we
//
// one transaction in, one transaction out; an item that applies no tone or a zero tone
// goes straight to the output state, and an item that applies a non-zero tone first
// passes through the 16-step shift-add multiplier followed by the 32-step restoring divider
// a new transaction is taken whenever the sequencer is idle, even while the
// previous result waits in the output register
// rst_n is synchronous; no clearing pass, the block is ready the cycle after reset
module buzzer_beep_pattern_generator (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  bbp_pkg::bbp_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output bbp_pkg::bbp_out_t out_data,
  input  logic             cfg_we,
  input  logic             cfg_addr,
  input  logic [31:0]      cfg_wdata
);
  import bbp_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic [31:0]        timer_clk_r, timer_clk_nxt;
  logic [15:0]        prescale_r, prescale_nxt;
  logic [1:0]         pat_r, pat_nxt;
  logic               on_r, on_nxt;
  logic [15:0]        elapsed_r, elapsed_nxt;
  logic [15:0]        freq_r, freq_nxt;
  logic [15:0]        on_time_r, on_time_nxt;
  logic [15:0]        off_time_r, off_time_nxt;
  logic signed [15:0] count_r, count_nxt;
  logic [31:0]        reload_r, reload_nxt;
  logic [31:0]        compare_r, compare_nxt;
  logic               drive_r, drive_nxt;
  logic               clear_r, clear_nxt;
  logic               out_valid_r, out_valid_nxt;
  bbp_out_t           out_data_r, out_data_nxt;

  logic               in_acc;
  logic               out_load;
  logic               apply_en;
  logic [15:0]        apply_f;
  logic               go_on;
  logic               go_off;
  logic [15:0]        el_inc;
  logic signed [15:0] cnt_dec;
  logic               mul_start;
  logic               mul_done;
  logic [31:0]        product;
  logic               div_start;
  logic               div_done;
  logic [31:0]        quotient;
  logic [31:0]        reload_calc;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_ready);

  assign el_inc  = (elapsed_r == ELAPSED_MAX) ? elapsed_r : elapsed_r + 16'd1;
  assign cnt_dec = (count_r > 16'sd0) ? count_r - 16'sd1 : count_r;
  // a zero quotient saturates the reload at zero
  assign reload_calc = (quotient == 32'd0) ? 32'd0 : quotient - 32'd1;

  always_comb begin
    timer_clk_nxt = timer_clk_r;
    prescale_nxt  = prescale_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        CFG_TIMER_CLOCK: timer_clk_nxt = cfg_wdata;
        CFG_PRESCALE:    prescale_nxt  = cfg_wdata[15:0];
        default:         ;
      endcase
    end
  end

  always_comb begin
    state_nxt    = state_r;
    pat_nxt      = pat_r;
    on_nxt       = on_r;
    elapsed_nxt  = elapsed_r;
    freq_nxt     = freq_r;
    on_time_nxt  = on_time_r;
    off_time_nxt = off_time_r;
    count_nxt    = count_r;
    reload_nxt   = reload_r;
    compare_nxt  = compare_r;
    drive_nxt    = drive_r;
    clear_nxt    = clear_r;
    apply_en     = 1'b0;
    apply_f      = freq_r;
    go_on        = 1'b0;
    go_off       = 1'b0;
    mul_start    = 1'b0;
    div_start    = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          clear_nxt = 1'b0;
          unique case (in_data.mode)
            MODE_TICK: begin
              elapsed_nxt = el_inc;
              if (pat_r == PAT_SINGLE) begin
                if (on_r && el_inc >= on_time_r) begin
                  pat_nxt = PAT_NONE;
                  go_off  = 1'b1;
                end
              end else if (pat_r == PAT_REPEAT) begin
                if (on_r && el_inc >= on_time_r) begin
                  go_off    = 1'b1;
                  count_nxt = cnt_dec;
                  if (cnt_dec == 16'sd0) begin
                    pat_nxt = PAT_NONE;
                  end
                end else if (!on_r && el_inc >= off_time_r) begin
                  go_on = 1'b1;
                end
              end
            end
            MODE_SINGLE: begin
              pat_nxt     = PAT_SINGLE;
              freq_nxt    = in_data.tone_freq;
              on_time_nxt = in_data.on_time;
              apply_f     = in_data.tone_freq;
              go_on       = 1'b1;
            end
            MODE_REPEAT: begin
              pat_nxt      = PAT_REPEAT;
              freq_nxt     = in_data.tone_freq;
              on_time_nxt  = in_data.on_time;
              off_time_nxt = in_data.off_time;
              count_nxt    = in_data.beep_count;
              apply_f      = in_data.tone_freq;
              go_on        = 1'b1;
            end
            MODE_STOP: begin
              pat_nxt = PAT_NONE;
              go_off  = 1'b1;
            end
            MODE_TONE: begin
              pat_nxt  = PAT_NONE;
              apply_en = 1'b1;
              apply_f  = in_data.tone_freq;
            end
            default: ;
          endcase

          if (go_on) begin
            apply_en    = 1'b1;
            on_nxt      = 1'b1;
            elapsed_nxt = '0;
          end
          if (go_off) begin
            apply_en    = 1'b1;
            apply_f     = '0;
            on_nxt      = 1'b0;
            elapsed_nxt = '0;
          end

          state_nxt = ST_OUT;
          if (apply_en) begin
            if (apply_f == 16'd0) begin
              compare_nxt = '0;
              drive_nxt   = 1'b0;
            end else begin
              drive_nxt = 1'b1;
              clear_nxt = 1'b1;
              mul_start = 1'b1;
              state_nxt = ST_MUL;
            end
          end
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          reload_nxt  = reload_calc;
          compare_nxt = {1'b0, reload_calc[31:1]};
          state_nxt   = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_data_nxt = out_data_r;
    if (out_load) begin
      out_data_nxt.pin_driven    = drive_r;
      out_data_nxt.reload_value  = reload_r;
      out_data_nxt.compare_value = compare_r;
      out_data_nxt.counter_clear = clear_r;
      out_data_nxt.pattern_mode  = pat_r;
      out_data_nxt.sounding      = on_r;
    end
    priority if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  bbp_mul u_mul (
    .clk       (clk),
    .rst_n     (rst_n),
    .start_i   (mul_start),
    .mcand_i   ({1'b0, prescale_r} + 17'd1),
    .mplier_i  (apply_f),
    .done_o    (mul_done),
    .product_o (product)
  );

  bbp_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (div_start),
    .dividend_i (timer_clk_r),
    .divisor_i  (product),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      timer_clk_r <= TIMER_CLOCK_RST;
      prescale_r  <= PRESCALE_RST;
      pat_r       <= PAT_NONE;
      on_r        <= 1'b0;
      elapsed_r   <= '0;
      freq_r      <= FREQ_RST;
      on_time_r   <= '0;
      off_time_r  <= '0;
      count_r     <= '0;
      reload_r    <= '0;
      compare_r   <= '0;
      drive_r     <= 1'b0;
      clear_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      timer_clk_r <= timer_clk_nxt;
      prescale_r  <= prescale_nxt;
      pat_r       <= pat_nxt;
      on_r        <= on_nxt;
      elapsed_r   <= elapsed_nxt;
      freq_r      <= freq_nxt;
      on_time_r   <= on_time_nxt;
      off_time_r  <= off_time_nxt;
      count_r     <= count_nxt;
      reload_r    <= reload_nxt;
      compare_r   <= compare_nxt;
      drive_r     <= drive_nxt;
      clear_r     <= clear_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a finished product always hands over to the divider
  a_mul_to_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL && mul_done) |=> (state_r == ST_DIV))
    else $error("multiplier done without divider start");

  // the divider only finishes while the sequencer waits for it
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("divider done outside its state");

  // compare is half of reload or zero, never above it
  a_cmp_le_reload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.compare_value <= out_data_r.reload_value))
    else $error("compare above reload");

  // a counter restart comes only with a driven pin
  a_clear_drives: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.counter_clear) |-> out_data_r.pin_driven)
    else $error("counter clear with pin released");

  // an accepted stop finishes without touching the arithmetic units
  a_stop_fast: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.mode == MODE_STOP) |=> (state_r == ST_OUT))
    else $error("stop command did not go straight to output");

endmodule

FILE: hw/rtl/bbp_mul.sv
// bbp_mul: shift-add multiplier, one multiplier bit per cycle
// forms (prescale + 1) * freq; depends on bbp_pkg
module bbp_mul (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start_i,
  input  logic [16:0] mcand_i,
  input  logic [15:0] mplier_i,
  output logic        done_o,
  output logic [31:0] product_o
);
  import bbp_pkg::*;

  localparam int CW = $clog2(MUL_STEPS);
  localparam logic [CW-1:0] LAST = CW'(MUL_STEPS - 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [31:0]   mcand_r, mcand_nxt;
  logic [15:0]   mplier_r, mplier_nxt;
  logic [31:0]   acc_r, acc_nxt;

  always_comb begin
    busy_nxt   = busy_r;
    done_nxt   = 1'b0;
    cnt_nxt    = cnt_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    acc_nxt    = acc_r;
    if (start_i) begin
      busy_nxt   = 1'b1;
      cnt_nxt    = '0;
      mcand_nxt  = {15'd0, mcand_i};
      mplier_nxt = mplier_i;
      acc_nxt    = '0;
    end else if (busy_r) begin
      if (mplier_r[0]) begin
        acc_nxt = acc_r + mcand_r;
      end
      mcand_nxt  = {mcand_r[30:0], 1'b0};
      mplier_nxt = {1'b0, mplier_r[15:1]};
      cnt_nxt    = cnt_r + 1'b1;
      if (cnt_r == LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    acc_r    <= acc_nxt;
  end

  assign done_o    = done_r;
  assign product_o = acc_r;

endmodule

FILE: hw/rtl/bbp_div.sv
// bbp_div: restoring divider, one quotient bit per cycle
// divides the timer clock by the prescaled tone; depends on bbp_pkg
module bbp_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [31:0] quotient_o
);
  import bbp_pkg::*;

  localparam int CW = $clog2(DIV_STEPS);
  localparam logic [CW-1:0] LAST = CW'(DIV_STEPS - 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [31:0]   rem_r, rem_nxt;
  logic [31:0]   quo_r, quo_nxt;
  logic [31:0]   div_r, div_nxt;
  logic [32:0]   trial;
  logic [32:0]   diff;

  assign trial = {rem_r, quo_r[31]};
  assign diff  = trial - {1'b0, div_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    div_nxt  = div_r;
    if (start_i) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend_i;
      div_nxt  = divisor_i;
    end else if (busy_r) begin
      // borrow out means the trial remainder is below the divisor
      if (!diff[32]) begin
        rem_nxt = diff[31:0];
        quo_nxt = {quo_r[30:0], 1'b1};
      end else begin
        rem_nxt = trial[31:0];
        quo_nxt = {quo_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    div_r <= div_nxt;
  end

  assign done_o     = done_r;
  assign quotient_o = quo_r;

endmodule

FILE: tb/tb_top.sv
// tb_top: self-checking testbench for buzzer_beep_pattern_generator
// drives commands and millisecond ticks, predicts each pwm/pattern result in place or takes it from the directed table
// depends on bbp_pkg and the buzzer_beep_pattern_generator rtl
`timescale 1ns / 100ps

module tb_top;
  import bbp_pkg::*;

  localparam logic [2:0] MODE_SPARE_5 = 3'd5;
  localparam logic [2:0] MODE_SPARE_7 = 3'd7;
  localparam int         CYCLE_LIMIT  = 1000000;
  localparam int         ITEMS_PER_SETTING = 70;

  typedef struct packed {
    bbp_in_t  item;
    logic     pinned;
    bbp_out_t want;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  bbp_in_t     in_data;
  logic        out_valid;
  logic        out_ready;
  bbp_out_t    out_data;
  logic        cfg_we;
  logic        cfg_addr;
  logic [31:0] cfg_wdata;

  // expectation typed into the directed table travels with the transaction
  logic        row_pinned;
  bbp_out_t    row_want;

  int          send_idle_pct;
  int          recv_idle_pct;
  int          bad_results;
  int          cycles;
  bbp_out_t    pending_pwm_states[$];

  // predictor copy of the sequencer
  logic [31:0]        bz_timer_hz;
  logic [15:0]        bz_prescale;
  logic [1:0]         bz_pattern;
  logic               bz_sounding;
  logic [15:0]        bz_elapsed_ms;
  logic [15:0]        bz_tone_hz;
  logic [15:0]        bz_on_ms;
  logic [15:0]        bz_off_ms;
  logic signed [15:0] bz_beeps_left;
  logic [31:0]        bz_reload;
  logic [31:0]        bz_compare;
  logic               bz_pin;
  logic               bz_restart;

  buzzer_beep_pattern_generator u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic void apply_pwm_tone(logic [15:0] hz);
    logic [63:0] divisor;
    logic [63:0] quot;
    if (hz == 16'd0) begin
      bz_compare = 32'd0;
      bz_pin     = 1'b0;
    end else begin
      divisor    = ({48'd0, bz_prescale} + 64'd1) * {48'd0, hz};
      quot       = {32'd0, bz_timer_hz} / divisor;
      bz_reload  = (quot == 64'd0) ? 32'd0 : quot[31:0] - 32'd1;
      bz_compare = bz_reload >> 1;
      bz_pin     = 1'b1;
      bz_restart = 1'b1;
    end
  endfunction

  function automatic void sound_on();
    apply_pwm_tone(bz_tone_hz);
    bz_sounding   = 1'b1;
    bz_elapsed_ms = 16'd0;
  endfunction

  function automatic void sound_off();
    apply_pwm_tone(16'd0);
    bz_sounding   = 1'b0;
    bz_elapsed_ms = 16'd0;
  endfunction

  function automatic void advance_pattern();
    if (bz_pattern == PAT_SINGLE) begin
      if (bz_sounding && bz_elapsed_ms >= bz_on_ms) begin
        bz_pattern = PAT_NONE;
        sound_off();
      end
    end else if (bz_pattern == PAT_REPEAT) begin
      if (bz_sounding && bz_elapsed_ms >= bz_on_ms) begin
        sound_off();
        // negative count never runs down
        if (bz_beeps_left > 0) bz_beeps_left = bz_beeps_left - 16'sd1;
        if (bz_beeps_left == 0) bz_pattern = PAT_NONE;
      end else if (!bz_sounding && bz_elapsed_ms >= bz_off_ms) begin
        sound_on();
      end
    end
  endfunction

  function automatic bbp_out_t buzzer_next(bbp_in_t it);
    bbp_out_t r;
    bz_restart = 1'b0;
    case (it.mode)
      MODE_TICK: begin
        if (bz_elapsed_ms != ELAPSED_MAX) bz_elapsed_ms = bz_elapsed_ms + 16'd1;
        advance_pattern();
      end
      MODE_SINGLE: begin
        bz_pattern = PAT_SINGLE;
        bz_tone_hz = it.tone_freq;
        bz_on_ms   = it.on_time;
        sound_on();
      end
      MODE_REPEAT: begin
        bz_pattern    = PAT_REPEAT;
        bz_tone_hz    = it.tone_freq;
        bz_on_ms      = it.on_time;
        bz_off_ms     = it.off_time;
        bz_beeps_left = it.beep_count;
        sound_on();
      end
      MODE_STOP: begin
        bz_pattern = PAT_NONE;
        sound_off();
      end
      MODE_TONE: begin
        // tone only: stored tone, phase and elapsed time stay
        bz_pattern = PAT_NONE;
        apply_pwm_tone(it.tone_freq);
      end
      default: ;
    endcase
    r.pin_driven    = bz_pin;
    r.reload_value  = bz_reload;
    r.compare_value = bz_compare;
    r.counter_clear = bz_restart;
    r.pattern_mode  = bz_pattern;
    r.sounding      = bz_sounding;
    return r;
  endfunction

  function automatic bbp_in_t random_command();
    bbp_in_t it;
    int      sel;
    sel = $urandom_range(99);
    if (sel < 60)      it.mode = MODE_TICK;
    else if (sel < 72) it.mode = MODE_SINGLE;
    else if (sel < 84) it.mode = MODE_REPEAT;
    else if (sel < 90) it.mode = MODE_STOP;
    else if (sel < 96) it.mode = MODE_TONE;
    else               it.mode = 3'($urandom_range(MODE_SPARE_7, MODE_SPARE_5));
    case ($urandom_range(3))
      0:       it.tone_freq = 16'd0;
      1:       it.tone_freq = 16'($urandom_range(2000, 1));
      default: it.tone_freq = 16'($urandom);
    endcase
    // short times keep patterns moving; the odd long one is noise
    it.on_time    = ($urandom_range(3) != 0) ? 16'($urandom_range(4)) : 16'($urandom);
    it.off_time   = ($urandom_range(3) != 0) ? 16'($urandom_range(4)) : 16'($urandom);
    it.beep_count = ($urandom_range(3) != 0) ? 16'($urandom_range(6) - 2) : 16'($urandom);
    return it;
  endfunction

  function automatic row_t cmd_row(logic [2:0] mode, logic [15:0] hz, logic [15:0] on_ms,
                                   logic [15:0] off_ms, logic signed [15:0] beeps,
                                   logic pinned, bbp_out_t want);
    row_t r;
    r.item.mode       = mode;
    r.item.tone_freq  = hz;
    r.item.on_time    = on_ms;
    r.item.off_time   = off_ms;
    r.item.beep_count = beeps;
    r.pinned          = pinned;
    r.want            = want;
    return r;
  endfunction

  task automatic send_item(bbp_in_t it, logic pinned, bbp_out_t want);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid   <= 1'b1;
    in_data    <= it;
    row_pinned <= pinned;
    row_want   <= want;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    // let the clock advance first so the last accepted transaction is already queued
    @(posedge clk);
    while (pending_pwm_states.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(logic addr, logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // predictor, scoreboard and receiver stalls
  always @(posedge clk) begin : watch
    bbp_out_t want;
    if (!rst_n) begin
      bz_timer_hz   = TIMER_CLOCK_RST;
      bz_prescale   = PRESCALE_RST;
      bz_pattern    = PAT_NONE;
      bz_sounding   = 1'b0;
      bz_elapsed_ms = 16'd0;
      bz_tone_hz    = FREQ_RST;
      bz_on_ms      = 16'd0;
      bz_off_ms     = 16'd0;
      bz_beeps_left = 16'sd0;
      bz_reload     = 32'd0;
      bz_compare    = 32'd0;
      bz_pin        = 1'b0;
      bz_restart    = 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_addr == CFG_TIMER_CLOCK) bz_timer_hz = cfg_wdata;
        else                             bz_prescale = cfg_wdata[15:0];
      end
      if (in_valid && in_ready) begin
        want = buzzer_next(in_data);
        if (row_pinned) want = row_want;
        pending_pwm_states.push_back(want);
      end
      if (out_valid && out_ready) begin
        if (pending_pwm_states.size() == 0) begin
          bad_results++;
          if (bad_results <= 10)
            $display("tb_top: unexpected result transaction %h", out_data);
        end else begin
          want = pending_pwm_states.pop_front();
          if (out_data.pin_driven !== want.pin_driven ||
              out_data.reload_value !== want.reload_value ||
              out_data.compare_value !== want.compare_value ||
              out_data.counter_clear !== want.counter_clear ||
              out_data.pattern_mode !== want.pattern_mode ||
              out_data.sounding !== want.sounding) begin
            bad_results++;
            if (bad_results <= 10) begin
              $write("tb_top: mismatch (exp/got) pin %b/%b reload %0d/%0d ",
                     want.pin_driven, out_data.pin_driven,
                     want.reload_value, out_data.reload_value);
              $display("compare %0d/%0d clear %b/%b pattern %0d/%0d sounding %b/%b",
                       want.compare_value, out_data.compare_value,
                       want.counter_clear, out_data.counter_clear,
                       want.pattern_mode, out_data.pattern_mode,
                       want.sounding, out_data.sounding);
            end
          end
        end
      end
    end
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin : stimulus
    row_t    directed_rows[$];
    bbp_out_t idle_out;
    int      ph;
    int      n;

    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_data       <= '0;
    row_pinned    <= 1'b0;
    row_want      <= '0;
    out_ready     <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_addr      <= CFG_TIMER_CLOCK;
    cfg_wdata     <= 32'd0;
    cycles        = 0;
    bad_results   = 0;
    send_idle_pct = 33;
    recv_idle_pct = 51;

    idle_out = {1'b0, 32'd999, 32'd0, 1'b0, PAT_NONE, 1'b0};
    // reset settings: 84 MHz over 84, so 1 kHz gives a reload of 999
    directed_rows.push_back(cmd_row(MODE_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF, -16'sd1, 1'b1,
                                    {1'b0, 32'd0, 32'd0, 1'b0, PAT_NONE, 1'b0}));
    directed_rows.push_back(cmd_row(MODE_TONE, 16'd1000, 16'd0, 16'd0, 16'sd0, 1'b1,
                                    {1'b1, 32'd999, 32'd499, 1'b1, PAT_NONE, 1'b0}));
    directed_rows.push_back(cmd_row(MODE_TONE, 16'd0, 16'd0, 16'd0, 16'sd0, 1'b1, idle_out));
    directed_rows.push_back(cmd_row(MODE_SPARE_5, 16'hFFFF, 16'hFFFF, 16'hFFFF, -16'sd1, 1'b1,
                                    idle_out));
    directed_rows.push_back(cmd_row(MODE_SPARE_7, 16'd5, 16'd5, 16'd5, 16'sd5, 1'b1, idle_out));
    directed_rows.push_back(cmd_row(MODE_TONE, 16'hFFFF, 16'd0, 16'd0, 16'sd0, 1'b1,
                                    {1'b1, 32'd14, 32'd7, 1'b1, PAT_NONE, 1'b0}));
    directed_rows.push_back(cmd_row(MODE_SINGLE, 16'hFFFF, 16'd2, 16'd0, 16'sd0, 1'b1,
                                    {1'b1, 32'd14, 32'd7, 1'b1, PAT_SINGLE, 1'b1}));
    directed_rows.push_back(cmd_row(MODE_TICK, 16'd0, 16'd0, 16'd0, 16'sd0, 1'b0, '0));
    directed_rows.push_back(cmd_row(MODE_TICK, 16'd0, 16'd0, 16'd0, 16'sd0, 1'b0, '0));
    directed_rows.push_back(cmd_row(MODE_REPEAT, 16'd1, 16'd1, 16'd1, 16'sd2, 1'b1,
                                    {1'b1, 32'd999999, 32'd499999, 1'b1, PAT_REPEAT, 1'b1}));
    for (n = 0; n < 4; n++)
      directed_rows.push_back(cmd_row(MODE_TICK, 16'd0, 16'd0, 16'd0, 16'sd0, 1'b0, '0));
    // endless pattern with zero on and off times toggles every tick
    directed_rows.push_back(cmd_row(MODE_REPEAT, 16'd2000, 16'd0, 16'd0, -16'sd32768, 1'b0,
                                    '0));
    for (n = 0; n < 3; n++)
      directed_rows.push_back(cmd_row(MODE_TICK, 16'd0, 16'd0, 16'd0, 16'sd0, 1'b0, '0));
    directed_rows.push_back(cmd_row(MODE_STOP, 16'd0, 16'd0, 16'd0, 16'sd0, 1'b0, '0));
    directed_rows.push_back(cmd_row(MODE_REPEAT, 16'd500, 16'd1, 16'd3, 16'sd0, 1'b0, '0));
    directed_rows.push_back(cmd_row(MODE_TICK, 16'd0, 16'd0, 16'd0, 16'sd0, 1'b0, '0));
    directed_rows.push_back(cmd_row(MODE_REPEAT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'sd32767,
                                    1'b0, '0));
    directed_rows.push_back(cmd_row(MODE_TONE, 16'd0, 16'd0, 16'd0, 16'sd0, 1'b0, '0));
    // silent beep: pin released while the pattern is in its on phase
    directed_rows.push_back(cmd_row(MODE_SINGLE, 16'd0, 16'd0, 16'd0, 16'sd0, 1'b0, '0));
    directed_rows.push_back(cmd_row(MODE_TICK, 16'd0, 16'd0, 16'd0, 16'sd0, 1'b0, '0));
    directed_rows.push_back(cmd_row(MODE_STOP, 16'd0, 16'd0, 16'd0, 16'sd0, 1'b0, '0));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_item(directed_rows[i].item, directed_rows[i].pinned, directed_rows[i].want);

    for (ph = 0; ph < 6; ph++) begin
      drain();
      if (ph == 2) begin
        send_idle_pct = 51;
        recv_idle_pct = 33;
      end else if (ph == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (ph)
        0: begin
          cfg_write(CFG_TIMER_CLOCK, 32'hFFFF_FFFF);
          cfg_write(CFG_PRESCALE, 32'd0);
        end
        1: begin
          // divisor always above the clock: reload saturates to zero
          cfg_write(CFG_TIMER_CLOCK, 32'd1);
          cfg_write(CFG_PRESCALE, 32'h0000_FFFF);
        end
        2: begin
          cfg_write(CFG_TIMER_CLOCK, $urandom);
          cfg_write(CFG_PRESCALE, $urandom_range(255));
        end
        3: begin
          cfg_write(CFG_TIMER_CLOCK, TIMER_CLOCK_RST);
          cfg_write(CFG_PRESCALE, {16'd0, PRESCALE_RST});
        end
        4: begin
          cfg_write(CFG_TIMER_CLOCK, $urandom_range(100000000, 1000000));
          cfg_write(CFG_PRESCALE, 32'd0);
        end
        default: begin
          cfg_write(CFG_TIMER_CLOCK, $urandom);
          cfg_write(CFG_PRESCALE, 32'h0000_FFFF);
        end
      endcase
      cfg_we <= 1'b0;
      for (n = 0; n < ITEMS_PER_SETTING; n++)
        send_item(random_command(), 1'b0, '0);
    end

    drain();
    repeat (60) @(posedge clk);
    if (bad_results == 0 && pending_pwm_states.size() == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule
